// ===== hdl/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// Cluster bitmap allocator package
// Shared widths, command codes and controller states for the allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int MAX_CLUSTERS = 4096;
    localparam int WORD_BITS    = 64;
    localparam int WORD_COUNT   = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W       = $clog2(WORD_COUNT);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int IDX_W        = 12;
    localparam int COUNT_W      = 13;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    typedef enum logic [1:0] {
        CMD_FIND = 2'd0,
        CMD_USED = 2'd1,
        CMD_FREE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_HOLD
    } state_t;

endpackage

// ===== hdl/cluster_bitmap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Cluster bitmap allocator
// First-fit free-space bitmap with a one-bit-per-word fullness summary.
// ----------------------------------------------------------------------------
// Each command passes from acceptance to a loaded result in order: the
// acceptance in ST_IDLE issues the read of one 64-bit map word, ST_READ
// modifies that word (for marks) and writes it back while the answer is
// formed, and ST_HOLD moves the answer into the output register once that
// register is free. The map memory has one read/write port. A find does not
// scan the map: a 64-bit summary in flip-flops marks each word that is all
// used, a priority encoder picks the lowest word that still has a clear bit,
// and one read of that word yields the lowest free cluster. The map needs no
// clearing pass after reset; a valid bit per word makes a never-written word
// read as all free. The cluster count register may be written at any time
// the block is idle; it takes effect on the next command. A new command is
// taken as soon as the previous one has reached the output register, even if
// that result beat is still waiting to be taken downstream.
// ----------------------------------------------------------------------------
module cluster_bitmap_allocator_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [cba_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 cmd,
    input  logic [cba_pkg::IDX_W-1:0]  cluster_index,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       status,
    output logic [cba_pkg::IDX_W-1:0]  free_index
);

    // Returns the position of the lowest clear bit; zero when none is clear.
    function automatic logic [5:0] first_zero(input logic [63:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            if (!v[i])
            begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

    cba_pkg::state_t state_reg, state_next;

    logic [cba_pkg::COUNT_W-1:0]   cluster_count_reg;
    logic [cba_pkg::WORD_BITS-1:0] mem [cba_pkg::WORD_COUNT];
    logic [cba_pkg::WORD_BITS-1:0] mem_q_reg;
    logic [cba_pkg::WORD_COUNT-1:0] word_valid_reg;
    logic [cba_pkg::WORD_COUNT-1:0] full_reg;

    logic [1:0]                    cmd_reg;
    logic [cba_pkg::ADDR_W-1:0]    addr_reg;
    logic [cba_pkg::BIT_W-1:0]     bit_reg;
    logic                          find_none_reg;

    logic                          res_status_reg;
    logic [cba_pkg::IDX_W-1:0]     res_index_reg;
    logic                          out_valid_reg;
    logic                          out_status_reg;
    logic [cba_pkg::IDX_W-1:0]     out_index_reg;

    logic                          accept;
    logic                          do_read;
    logic                          do_load;
    logic [cba_pkg::ADDR_W-1:0]    rd_addr;
    logic [cba_pkg::WORD_BITS-1:0] rd_word;
    logic [cba_pkg::WORD_BITS-1:0] wr_word;
    logic                          wr_en;
    logic                          res_status_next;
    logic [cba_pkg::IDX_W-1:0]     res_index_next;
    logic [cba_pkg::BIT_W-1:0]     zero_pos;
    logic [cba_pkg::IDX_W-1:0]     found_idx;
    logic                          idx_in_range;

    assign accept  = in_valid && in_ready;
    assign rd_addr = (cmd == cba_pkg::CMD_FIND) ? first_zero(full_reg)
                                               : cluster_index[cba_pkg::IDX_W-1:cba_pkg::BIT_W];
    assign rd_word = word_valid_reg[addr_reg] ? mem_q_reg : '0;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cba_pkg::ST_READ;
                end
            end
            cba_pkg::ST_READ:
            begin
                state_next = cba_pkg::ST_HOLD;
            end
            cba_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = cba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cba_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_ready = 1'b0;
        do_read  = 1'b0;
        do_load  = 1'b0;
        unique case (state_reg)
            cba_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                do_read  = in_valid;
            end
            cba_pkg::ST_READ:
            begin
                do_read = 1'b0;
            end
            cba_pkg::ST_HOLD:
            begin
                do_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Modify stage: works on the word read back from the map.
    always_comb
    begin
        zero_pos        = first_zero(rd_word);
        found_idx       = {addr_reg, zero_pos};
        idx_in_range    = {1'b0, addr_reg, bit_reg} < cluster_count_reg;
        wr_word         = rd_word;
        wr_en           = 1'b0;
        res_status_next = 1'b1;
        res_index_next  = '0;
        unique case (cba_pkg::cmd_t'(cmd_reg))
            cba_pkg::CMD_FIND:
            begin
                if (!find_none_reg && ({1'b0, found_idx} < cluster_count_reg))
                begin
                    res_status_next = 1'b0;
                    res_index_next  = found_idx;
                end
            end
            cba_pkg::CMD_USED:
            begin
                if (idx_in_range)
                begin
                    wr_word[bit_reg] = 1'b1;
                    wr_en            = 1'b1;
                    res_status_next  = 1'b0;
                end
            end
            cba_pkg::CMD_FREE:
            begin
                if (idx_in_range)
                begin
                    wr_word[bit_reg] = 1'b0;
                    wr_en            = 1'b1;
                    res_status_next  = 1'b0;
                end
            end
            default:
            begin
                res_status_next = 1'b1;
            end
        endcase
    end

    // Map memory: one synchronous port, read on acceptance, written back in
    // the next cycle.
    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            mem_q_reg <= mem[rd_addr];
        end
        if (state_reg == cba_pkg::ST_READ && wr_en)
        begin
            mem[addr_reg] <= wr_word;
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= cmd;
            addr_reg      <= rd_addr;
            bit_reg       <= cluster_index[cba_pkg::BIT_W-1:0];
            find_none_reg <= &full_reg;
        end
        if (state_reg == cba_pkg::ST_READ)
        begin
            res_status_reg <= res_status_next;
            res_index_reg  <= res_index_next;
        end
        if (do_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
        end
    end

    // Control state, summary and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= cba_pkg::ST_IDLE;
            cluster_count_reg <= cba_pkg::COUNT_RESET;
            word_valid_reg    <= '0;
            full_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                cluster_count_reg <= cfg_wr_data;
            end
            if (state_reg == cba_pkg::ST_READ && wr_en)
            begin
                word_valid_reg[addr_reg] <= 1'b1;
                full_reg[addr_reg]       <= &wr_word;
            end
            if (do_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign free_index = out_index_reg;

    // An accepted command always moves on to its modify cycle.
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == cba_pkg::ST_READ)
        else $error("accepted command did not enter the modify cycle");

    // The fullness summary agrees with the word read back from the map.
    a_summary_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cba_pkg::ST_READ |-> full_reg[addr_reg] == &rd_word)
        else $error("summary bit disagrees with map word");

    // A find that picked a word from the summary sees a clear bit in it.
    a_find_has_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cba_pkg::ST_READ && cmd_reg == cba_pkg::CMD_FIND && !find_none_reg)
        |-> !(&rd_word))
        else $error("find selected a word with no free cluster");

    // A finished result does not overwrite a beat that is still waiting.
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cba_pkg::ST_HOLD && out_valid_reg && !out_ready)
        |=> state_reg == cba_pkg::ST_HOLD)
        else $error("result left hold stage while output was stalled");

endmodule

// ===== verif/tb_cluster_bitmap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Cluster bitmap allocator testbench
// Drives find, mark-used and mark-free commands through the valid/ready
// command port under random idling and backpressure, and changes the cluster
// count between phases. A scoreboard keeps its own copy of the usage map and
// the count, predicts one result beat per command, and compares every result
// beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cluster_bitmap_allocator_top;

    // Command code that the block must answer with a plain rejection.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int BURST_BEATS      = 24;
    localparam int PHASE_BEATS      = 100;
    localparam int SETTLE_CYCLES    = 20;
    localparam int TIMEOUT_TIME     = 5_000_000;

    // One predicted result beat.
    typedef struct packed {
        logic                      status;
        logic [cba_pkg::IDX_W-1:0] free_index;
    } alloc_result_t;

    // Scoreboard: a private usage map and cluster count, and the queue of
    // result beats that are still owed by the block.
    class alloc_scoreboard_t;
        bit                          used_map [cba_pkg::MAX_CLUSTERS];
        logic [cba_pkg::COUNT_W-1:0] cluster_count;
        alloc_result_t               owed_q [$];
        int                          error_count;

        function new();
            cluster_count = cba_pkg::COUNT_RESET;
            error_count   = 0;
        endfunction

        function void set_count(input logic [cba_pkg::COUNT_W-1:0] value);
            cluster_count = value;
        endfunction

        // Counts above the capacity of the map behave as the full map.
        function int live_count();
            return (cluster_count > cba_pkg::MAX_CLUSTERS) ? cba_pkg::MAX_CLUSTERS
                                                            : int'(cluster_count);
        endfunction

        function int lowest_free();
            int lim;
            lim = live_count();
            for (int c = 0; c < lim; c++)
                if (!used_map[c])
                    return c;
            return -1;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Called once for every command beat taken by the block.
        function void note_command(input logic [1:0] code,
                                   input logic [cba_pkg::IDX_W-1:0] idx);
            alloc_result_t r;
            int            lf;
            r.status     = 1'b1;
            r.free_index = '0;
            case (code)
                cba_pkg::CMD_FIND:
                begin
                    lf = lowest_free();
                    if (lf >= 0)
                    begin
                        r.status     = 1'b0;
                        r.free_index = lf[cba_pkg::IDX_W-1:0];
                    end
                end
                cba_pkg::CMD_USED, cba_pkg::CMD_FREE:
                begin
                    if (int'(idx) < live_count())
                    begin
                        used_map[idx] = (code == cba_pkg::CMD_USED);
                        r.status      = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            owed_q.push_back(r);
        endfunction

        function void check_result(input logic st, input logic [cba_pkg::IDX_W-1:0] fi);
            alloc_result_t e;
            if (owed_q.size() == 0)
            begin
                $error("result beat with nothing outstanding: status %0d free_index %0d",
                       st, fi);
                error_count++;
                return;
            end
            e = owed_q.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                error_count++;
            end
            if (fi !== e.free_index)
            begin
                $error("free_index: expected %0d, actual %0d", e.free_index, fi);
                error_count++;
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [cba_pkg::COUNT_W-1:0] cfg_wr_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [1:0]                  cmd;
    logic [cba_pkg::IDX_W-1:0]   cluster_index;
    logic                        out_valid;
    logic                        out_ready;
    logic                        status;
    logic [cba_pkg::IDX_W-1:0]   free_index;

    alloc_scoreboard_t sb = new();

    // Handshake between the stimulus process and the result sink for the long
    // backpressure stretch, and a switch that makes the sender go gap-free.
    bit hold_request = 1'b0;
    bit hold_active  = 1'b0;
    bit no_gaps      = 1'b0;

    // Count settings of the random phases: ordinary sizes, word boundaries,
    // a count of one, a count of zero and counts above the capacity. Going
    // from 130 down to 8 leaves used bits above the new count.
    logic [cba_pkg::COUNT_W-1:0] phase_counts [12] = '{
        13'd4096, 13'd130, 13'd8, 13'd1, 13'd64, 13'd65,
        13'd8191, 13'd0, 13'd200, 13'd4097, 13'd63, 13'd4096
    };

    cluster_bitmap_allocator_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .cluster_index (cluster_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .free_index    (free_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result monitor. Outputs are sampled at the rising edge, before any
    // register of the block has moved, so the beat seen here is the one that
    // the handshake at this edge takes.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(status, free_index);
    end

    // Result sink: ready in runs of random length with mostly short stalls
    // between them and now and then a long one. On request it holds off for
    // a long stretch so the pipeline fills and the command port backs up.
    initial
    begin : result_sink
        int run_len;
        int stall_len;
        int pick;
        out_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                out_ready   <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_active  = 1'b0;
            end
            pick = int'($urandom_range(0, 99));
            if (pick < 10)
                run_len = int'($urandom_range(50, 120));
            else
                run_len = int'($urandom_range(1, 20));
            pick = int'($urandom_range(0, 99));
            if (pick < 60)
                stall_len = 0;
            else if (pick < 85)
                stall_len = int'($urandom_range(1, 4));
            else if (pick < 97)
                stall_len = int'($urandom_range(5, 15));
            else
                stall_len = int'($urandom_range(30, 60));
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            if (stall_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // Offers one command beat and returns at the edge that takes it. When no
    // gap follows, valid stays high and the caller must offer the next beat
    // in the same time step.
    task automatic send_command(input logic [1:0] code,
                                input logic [cba_pkg::IDX_W-1:0] idx);
        int gap;
        int pick;
        gap = 0;
        in_valid      <= 1'b1;
        cmd           <= code;
        cluster_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_command(code, idx);
        if (!no_gaps)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 55)
                gap = 0;
            else if (pick < 85)
                gap = int'($urandom_range(1, 3));
            else if (pick < 97)
                gap = int'($urandom_range(4, 10));
            else
                gap = int'($urandom_range(20, 40));
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering beats and waits until every predicted beat has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // The count register is only written while nothing is in flight.
    task automatic write_cluster_count(input logic [cba_pkg::COUNT_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_count(value);
    endtask

    // Mostly an index inside the live range, sometimes exactly the first
    // index past it; with no live range, any index at all.
    function automatic logic [cba_pkg::IDX_W-1:0] pick_index(input int lim);
        if (lim <= 0)
            return cba_pkg::IDX_W'($urandom());
        if (lim < cba_pkg::MAX_CLUSTERS && $urandom_range(0, 9) == 0)
            return cba_pkg::IDX_W'(lim);
        return cba_pkg::IDX_W'($urandom_range(0, lim - 1));
    endfunction

    // Corner cases first: finds on an empty and a partly used map, the
    // extreme indices, the unused command code, repeated frees, a count of
    // zero, a count of one with its map full, a count above the capacity and
    // a lowered count with used bits left above it.
    task automatic run_directed();
        send_command(cba_pkg::CMD_FIND, '0);
        send_command(cba_pkg::CMD_USED, '0);
        send_command(cba_pkg::CMD_FIND, '1);
        send_command(cba_pkg::CMD_USED, '1);
        send_command(cba_pkg::CMD_FREE, '1);
        send_command(cba_pkg::CMD_USED, 12'd1);
        send_command(cba_pkg::CMD_FIND, '0);
        send_command(CMD_UNUSED, '1);
        send_command(CMD_UNUSED, '0);
        send_command(cba_pkg::CMD_FREE, '0);
        send_command(cba_pkg::CMD_FREE, '0);

        write_cluster_count(13'd0);
        send_command(cba_pkg::CMD_FIND, '0);
        send_command(cba_pkg::CMD_USED, '0);
        send_command(cba_pkg::CMD_FREE, 12'd1);

        write_cluster_count(13'd1);
        send_command(cba_pkg::CMD_FIND, '0);
        send_command(cba_pkg::CMD_USED, '0);
        send_command(cba_pkg::CMD_FIND, '0);
        send_command(cba_pkg::CMD_USED, 12'd1);

        write_cluster_count(13'h1FFF);
        send_command(cba_pkg::CMD_USED, '1);
        send_command(cba_pkg::CMD_FIND, '0);

        write_cluster_count(13'd2);
        send_command(cba_pkg::CMD_FIND, '0);
        send_command(cba_pkg::CMD_FREE, '1);
    endtask

    // Random traffic. Between 25 and 60 percent of the picks are allocation:
    // a find followed by marking the cluster it returned, which walks the map
    // up through full words. The rest frees and marks random clusters, uses
    // indices anywhere in the field, sends the unused code and lone finds.
    // Now and then the sender waits until every result beat has come back.
    task automatic run_random(input int n_beats);
        int               sent;
        int               pick;
        int               lim;
        int               lf;
        int               fill_weight;
        logic [1:0]       code;
        sent        = 0;
        fill_weight = int'($urandom_range(25, 60));
        while (sent < n_beats)
        begin
            lim  = sb.live_count();
            pick = int'($urandom_range(0, 99));
            if (pick < fill_weight)
            begin
                send_command(cba_pkg::CMD_FIND, cba_pkg::IDX_W'($urandom()));
                sent++;
                lf = sb.lowest_free();
                if (lf >= 0)
                begin
                    send_command(cba_pkg::CMD_USED, lf[cba_pkg::IDX_W-1:0]);
                    sent++;
                end
            end
            else if (pick < fill_weight + 15)
            begin
                send_command(cba_pkg::CMD_FREE, pick_index(lim));
                sent++;
            end
            else if (pick < fill_weight + 25)
            begin
                send_command(cba_pkg::CMD_USED, pick_index(lim));
                sent++;
            end
            else if (pick < 92)
            begin
                code = $urandom_range(0, 1) ? cba_pkg::CMD_USED : cba_pkg::CMD_FREE;
                send_command(code, cba_pkg::IDX_W'($urandom()));
                sent++;
            end
            else if (pick < 96)
            begin
                send_command(CMD_UNUSED, cba_pkg::IDX_W'($urandom()));
                sent++;
            end
            else if (pick < 99)
            begin
                send_command(cba_pkg::CMD_FIND, cba_pkg::IDX_W'($urandom()));
                sent++;
            end
            else
                wait_drained();
        end
    endtask

    // Asks the sink for its long hold and then offers beats back to back, so
    // the block fills up and has to drop in_ready.
    task automatic backpressure_burst();
        in_valid <= 1'b0;
        @(posedge clk);
        hold_request = 1'b1;
        wait (hold_active);
        no_gaps = 1'b1;
        for (int k = 0; k < BURST_BEATS; k++)
            send_command($urandom_range(0, 1) ? cba_pkg::CMD_FIND : cba_pkg::CMD_USED,
                         pick_index(sb.live_count()));
        no_gaps = 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        in_valid      <= 1'b0;
        cmd           <= cba_pkg::CMD_FIND;
        cluster_index <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        foreach (phase_counts[p])
        begin
            write_cluster_count(phase_counts[p]);
            if (p == 1 || p == 6)
                backpressure_burst();
            run_random(PHASE_BEATS);
        end

        // Every command has been taken; let the last beats come out and give
        // the block time to show any stray beat.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog for a block that hangs or loses result beats.
    initial
    begin : watchdog
        #(TIMEOUT_TIME);
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== cluster_bitmap_allocator_top.f =====
hdl/cba_pkg.sv
hdl/cluster_bitmap_allocator_top.sv
verif/tb_cluster_bitmap_allocator_top.sv
